### src/topt_pkg.sv
// ----------------------------------------------------------------------------
// topt_pkg
// Shared types and constants of the two-opt route optimizer.
// ----------------------------------------------------------------------------
package topt_pkg;

  localparam int unsigned MaxNodesDefault = 64;
  localparam int unsigned MaxRouteDefault = 32;
  localparam int unsigned NodeW = 6;
  localparam int unsigned DistW = 24;
  localparam int unsigned TimeW = 16;
  localparam int unsigned CostW = 30;
  localparam int unsigned PosW  = 5;
  localparam int unsigned AccW  = 36;
  localparam int unsigned TAccW = 40;

  typedef enum logic [1:0] {
    OP_WINDOW = 2'd0,
    OP_PAIR   = 2'd1,
    OP_ROUTE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic [DistW-1:0] distance;
    logic [TimeW-1:0] early_time;
    logic [TimeW-1:0] late_time;
    logic [TimeW-1:0] service_time;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [PosW-1:0]  position;
    logic [NodeW-1:0] customer;
    logic [CostW-1:0] route_cost;
    logic             final_flag;
  } out_item_t;

  // controller to datapath commands
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_BASE_START,
    CMD_BASE_STEP,
    CMD_TRIAL_START,
    CMD_TRIAL_STEP,
    CMD_ACCEPT,
    CMD_COPY_STEP,
    CMD_EMIT_START,
    CMD_EMIT_STEP
  } cmd_e;

  typedef struct packed {
    logic done;     // current sweep finished
    logic improve;  // trial shorter and feasible
  } dp_status_t;

endpackage

### src/topt_ram.sv
// ----------------------------------------------------------------------------
// topt_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module topt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/topt_datapath.sv
// ----------------------------------------------------------------------------
// topt_datapath
// Route storage, windows, distance table and the cost/feasibility walker.
// Each route element is walked in steps: issue reads, wait, add.
// ----------------------------------------------------------------------------
module topt_datapath #(
  parameter int unsigned MaxNodes = topt_pkg::MaxNodesDefault,
  parameter int unsigned MaxRoute = topt_pkg::MaxRouteDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  topt_pkg::in_item_t       item_i,
  input  topt_pkg::cmd_e           cmd_i,
  input  logic [$clog2(MaxRoute+1)-1:0] count_i,
  input  logic [$clog2(MaxRoute)-1:0]   seg_i_i,
  input  logic [$clog2(MaxRoute)-1:0]   seg_k_i,
  output topt_pkg::dp_status_t     status_o,
  output topt_pkg::out_item_t      out_item_o
);

  localparam int unsigned RW    = $clog2(MaxRoute);
  localparam int unsigned CW    = $clog2(MaxRoute + 1);
  localparam int unsigned NW    = $clog2(MaxNodes);
  localparam int unsigned Pairs = (MaxNodes * (MaxNodes - 1)) / 2;
  localparam int unsigned PW    = $clog2(Pairs);
  localparam int unsigned ProdW = PW + 2;
  localparam int unsigned TW    = topt_pkg::TimeW;
  localparam int unsigned WinW  = 3 * TW;

  // route registers: read at fixed element per lane, small
  logic [topt_pkg::NodeW-1:0] route_q [MaxRoute];
  logic [topt_pkg::NodeW-1:0] trial_q [MaxRoute];

  // walker
  logic [CW-1:0]             pos_q, pos_d;
  logic [1:0]                ph_q, ph_d;
  logic [topt_pkg::NodeW-1:0] prev_q, prev_d, cur_q, cur_d;
  logic                      tail_q, tail_d;
  logic [topt_pkg::AccW-1:0]  acc_q, acc_d, best_q, best_d;
  logic [topt_pkg::TAccW-1:0] tim_q, tim_d;
  logic                      ok_q, ok_d, trial_mode_q, trial_mode_d;
  logic                      done_q, done_d, imp_q, imp_d;
  logic [topt_pkg::CostW-1:0] cost_q, cost_d;
  logic [CW-1:0]             emit_q, emit_d;

  // node number below MaxNodes
  function automatic logic node_in(input logic [topt_pkg::NodeW-1:0] v);
    node_in = (32'(v) < MaxNodes);
  endfunction

  // pair index of an unordered node pair
  logic [topt_pkg::NodeW-1:0] lo, hi;
  logic                       pair_ok;
  logic [PW-1:0]              pair_idx;
  logic [ProdW-1:0]           prod;
  logic [topt_pkg::NodeW-1:0] qa, qb;

  always_comb begin
    lo = (qa < qb) ? qa : qb;
    hi = (qa < qb) ? qb : qa;
    pair_ok = (lo != hi) && node_in(hi);
    prod = ProdW'(lo) * (ProdW'(2 * MaxNodes - 1) - ProdW'(lo));
    pair_idx = PW'((prod >> 1) + ProdW'(hi - lo - 1'b1));
  end

  // memories
  logic              d_we, w_we;
  logic [topt_pkg::DistW-1:0] d_rdata;
  logic [WinW-1:0]            w_rdata;
  logic                       pair_ok_q;
  logic [NW-1:0]              w_raddr;

  assign qa = load_i ? item_i.node_a : prev_q;
  assign qb = load_i ? item_i.node_b : cur_q;
  assign d_we = load_i && (item_i.operation == topt_pkg::OP_PAIR) && pair_ok;
  assign w_we = load_i && (item_i.operation == topt_pkg::OP_WINDOW) &&
                node_in(item_i.node_a);
  assign w_raddr = NW'(cur_q);

  topt_ram #(.Width(topt_pkg::DistW), .Depth(Pairs)) u_dist (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(pair_idx),
    .wdata_i(item_i.distance),
    .raddr_i(pair_idx),
    .rdata_o(d_rdata)
  );

  topt_ram #(.Width(WinW), .Depth(MaxNodes)) u_win (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(NW'(item_i.node_a)),
    .wdata_i({item_i.early_time, item_i.late_time, item_i.service_time}),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  // walked node at position p of the active sequence
  function automatic logic [topt_pkg::NodeW-1:0] pick(
    input logic [topt_pkg::NodeW-1:0] r [MaxRoute], input logic [CW-1:0] p);
    pick = r[RW'(p)];
  endfunction

  logic [topt_pkg::NodeW-1:0] nxt_node;
  logic [topt_pkg::TAccW-1:0] arr;
  logic [topt_pkg::TimeW-1:0] w_e, w_l, w_s;

  always_comb begin
    nxt_node = trial_mode_q ? pick(trial_q, pos_q) : pick(route_q, pos_q);
    w_e = node_in(cur_q) ? w_rdata[2*TW +: TW] : '0;
    w_l = node_in(cur_q) ? w_rdata[TW +: TW] : '0;
    w_s = node_in(cur_q) ? w_rdata[0 +: TW] : '0;
    arr = tim_q + topt_pkg::TAccW'(pair_ok_q ? d_rdata[topt_pkg::DistW-1:8] : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_ok_q <= 1'b0;
    end else begin
      pair_ok_q <= pair_ok;
    end
  end

  always_comb begin
    pos_d = pos_q; ph_d = ph_q; prev_d = prev_q; cur_d = cur_q; tail_d = tail_q;
    acc_d = acc_q; best_d = best_q; tim_d = tim_q; ok_d = ok_q;
    trial_mode_d = trial_mode_q; done_d = 1'b0; imp_d = imp_q;
    cost_d = cost_q; emit_d = emit_q;
    unique case (cmd_i) inside
      topt_pkg::CMD_BASE_START, topt_pkg::CMD_TRIAL_START: begin
        trial_mode_d = (cmd_i == topt_pkg::CMD_TRIAL_START);
        pos_d = '0; ph_d = 2'd0; prev_d = '0; tail_d = 1'b0;
        acc_d = '0; tim_d = '0; ok_d = 1'b1; imp_d = 1'b0;
        cur_d = trial_mode_d ? trial_q[0] : route_q[0];
      end
      topt_pkg::CMD_BASE_STEP, topt_pkg::CMD_TRIAL_STEP: begin
        case (ph_q)
          2'd0: ph_d = 2'd1;
          2'd1: ph_d = 2'd2;
          default: begin
            ph_d = 2'd0;
            acc_d = acc_q + topt_pkg::AccW'(pair_ok_q ? d_rdata : '0);
            if (!tail_q) begin
              if (arr > topt_pkg::TAccW'(w_l)) ok_d = 1'b0;
              tim_d = ((arr < topt_pkg::TAccW'(w_e)) ? topt_pkg::TAccW'(w_e) : arr)
                      + topt_pkg::TAccW'(w_s);
            end
            prev_d = cur_q;
            if (tail_q) begin
              done_d = 1'b1;
              if (!trial_mode_q) begin
                best_d = acc_d;
                cost_d = acc_d[topt_pkg::CostW-1:0];
              end else begin
                imp_d = (acc_d < best_q) && ok_d;
              end
            end else if (pos_q + 1'b1 == count_i) begin
              tail_d = 1'b1;
              cur_d = '0;
            end else begin
              pos_d = pos_q + 1'b1;
              cur_d = trial_mode_q ? pick(trial_q, pos_q + 1'b1)
                                   : pick(route_q, pos_q + 1'b1);
            end
          end
        endcase
      end
      topt_pkg::CMD_ACCEPT: begin
        best_d = acc_q;
      end
      topt_pkg::CMD_EMIT_START: emit_d = '0;
      topt_pkg::CMD_EMIT_STEP:  emit_d = emit_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0; pos_q <= '0; tail_q <= 1'b0; done_q <= 1'b0; imp_q <= 1'b0;
      trial_mode_q <= 1'b0; cost_q <= '0; emit_q <= '0; ok_q <= 1'b1;
    end else begin
      ph_q <= ph_d; pos_q <= pos_d; tail_q <= tail_d; done_q <= done_d;
      imp_q <= imp_d; trial_mode_q <= trial_mode_d; cost_q <= cost_d;
      emit_q <= emit_d; ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; cur_q <= cur_d; acc_q <= acc_d; best_q <= best_d; tim_q <= tim_d;
  end

  // route store, trial build and accept copy
  always_ff @(posedge clk_i) begin
    if (load_i && item_i.operation == topt_pkg::OP_ROUTE && count_i < CW'(MaxRoute)) begin
      route_q[RW'(count_i)] <= item_i.node_a;
    end
    if (cmd_i == topt_pkg::CMD_TRIAL_START) begin
      for (int c = 0; c < MaxRoute; c++) begin
        if (RW'(c) >= seg_i_i && RW'(c) <= seg_k_i) begin
          trial_q[c] <= route_q[RW'(seg_k_i - (RW'(c) - seg_i_i))];
        end else begin
          trial_q[c] <= route_q[c];
        end
      end
    end
    if (cmd_i == topt_pkg::CMD_ACCEPT) begin
      for (int c = 0; c < MaxRoute; c++) route_q[c] <= trial_q[c];
    end
  end

  assign status_o.done    = done_q;
  assign status_o.improve = imp_q;
  assign out_item_o.position   = topt_pkg::PosW'(emit_q);
  assign out_item_o.customer   = pick(route_q, emit_q);
  assign out_item_o.route_cost = cost_q;
  assign out_item_o.final_flag = (emit_q + 1'b1 == count_i);

endmodule

### src/topt_ctrl.sv
// ----------------------------------------------------------------------------
// topt_ctrl
// Sequencer over loading, base cost, trial reversals, passes and emission.
// ----------------------------------------------------------------------------
module topt_ctrl #(
  parameter int unsigned MaxRoute = topt_pkg::MaxRouteDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  topt_pkg::in_item_t   in_item_i,
  output logic                 load_o,
  output topt_pkg::cmd_e       cmd_o,
  output logic [$clog2(MaxRoute+1)-1:0] count_o,
  output logic [$clog2(MaxRoute)-1:0]   seg_i_o,
  output logic [$clog2(MaxRoute)-1:0]   seg_k_o,
  input  topt_pkg::dp_status_t status_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);

  localparam int unsigned RW = $clog2(MaxRoute);
  localparam int unsigned CW = $clog2(MaxRoute + 1);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_BASE  = 7'b0000010,
    S_TSTRT = 7'b0000100,
    S_TRIAL = 7'b0001000,
    S_NEXT  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, emitted_q, emitted_d;
  logic [RW-1:0] i_q, i_d, k_q, k_d;
  logic [1:0]    pass_q, pass_d;
  logic          start_q, start_d;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_LOAD);
  assign load_o = acc;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; k_d = k_q; pass_d = pass_q;
    start_d = 1'b0; emitted_d = emitted_q; cmd_o = topt_pkg::CMD_IDLE;
    unique case (state_q)
      S_LOAD: begin
        if (acc && in_item_i.operation == topt_pkg::OP_ROUTE) begin
          if (cnt_q < CW'(MaxRoute)) cnt_d = cnt_q + 1'b1;
          if (in_item_i.last && cnt_d != '0) begin
            state_d = S_BASE; start_d = 1'b1; pass_d = '0;
          end
        end
      end
      S_BASE: begin
        cmd_o = start_q ? topt_pkg::CMD_BASE_START : topt_pkg::CMD_BASE_STEP;
        if (!start_q && status_i.done) begin
          if (cnt_q > CW'(2) && pass_q < 2'd2) begin
            state_d = S_TSTRT; i_d = '0; k_d = RW'(1);
          end else begin
            state_d = S_EMIT; emitted_d = '0;
            cmd_o = topt_pkg::CMD_EMIT_START;
          end
        end
      end
      S_TSTRT: begin
        cmd_o = topt_pkg::CMD_TRIAL_START; state_d = S_TRIAL; start_d = 1'b1;
      end
      S_TRIAL: begin
        cmd_o = start_q ? topt_pkg::CMD_TRIAL_START : topt_pkg::CMD_TRIAL_STEP;
        if (status_i.done) state_d = S_NEXT;
      end
      S_NEXT: begin
        if (status_i.improve) begin
          cmd_o = topt_pkg::CMD_ACCEPT; pass_d = '0;
        end
        if (CW'(k_q) + 1'b1 < cnt_q) begin
          k_d = k_q + 1'b1; state_d = S_TSTRT;
        end else if (CW'(i_q) + CW'(2) < cnt_q) begin
          i_d = i_q + 1'b1; k_d = i_q + RW'(2); state_d = S_TSTRT;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        pass_d = pass_q + 1'b1; state_d = S_BASE; start_d = 1'b1;
      end
      S_EMIT: begin
        if (!out_stall_i) begin
          cmd_o = topt_pkg::CMD_EMIT_STEP;
          emitted_d = emitted_q + 1'b1;
          if (emitted_q + 1'b1 == cnt_q) begin
            state_d = S_LOAD; cnt_d = '0;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; cnt_q <= '0; i_q <= '0; k_q <= '0; pass_q <= '0;
      start_q <= 1'b0; emitted_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; i_q <= i_d; k_q <= k_d; pass_q <= pass_d;
      start_q <= start_d; emitted_q <= emitted_d;
    end
  end

  assign count_o = cnt_q;
  assign seg_i_o = i_q;
  assign seg_k_o = k_q;
  assign out_valid_o = (state_q == S_EMIT);

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during emit");
  a_seg_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRIAL) |-> (k_q > i_q)) else $error("bad segment");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxRoute)) else $error("route count overflow");
  a_emit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0)) else $error("emit of empty route");
`endif

endmodule

### src/two_opt_time_window_route.sv
// ----------------------------------------------------------------------------
// two_opt_time_window_route
// Two-opt route improvement under node time windows.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries loads: a node window, a
// distance pair or a route element. Loads are taken one per cycle, back to
// back. A route element with last set starts the search; input stalls until
// the route has been sent out.
// Search: each closed-route walk over n customers opens with a start command
// and prices every leg, both depot legs included, before it reports done.
// A pass is one walk of the current route, n(n-1)/2 reversals each priced
// by one walk, and a closing state. Passes repeat until a pass finds no
// improvement after one that did, or two passes find none; a last walk then
// prices the route. Routes of two or fewer customers take only that walk.
// Output channel (out_valid_o / out_stall_i) sends one transfer per customer,
// one per cycle, in route order, cost on every transfer, final_flag on the
// last. A stall holds the current transfer. Reset empties the route and
// returns to loading; window and distance contents are undefined until written.
// ----------------------------------------------------------------------------
module two_opt_time_window_route #(
  parameter int unsigned MaxNodes = topt_pkg::MaxNodesDefault,
  parameter int unsigned MaxRoute = topt_pkg::MaxRouteDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  topt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output topt_pkg::out_item_t out_item_o
);

  logic                          load;
  topt_pkg::cmd_e                cmd;
  topt_pkg::dp_status_t          status;
  logic [$clog2(MaxRoute+1)-1:0] count;
  logic [$clog2(MaxRoute)-1:0]   seg_i, seg_k;

  topt_ctrl #(.MaxRoute(MaxRoute)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .load_o(load), .cmd_o(cmd), .count_o(count), .seg_i_o(seg_i), .seg_k_o(seg_k),
    .status_i(status), .out_valid_o, .out_stall_i
  );

  topt_datapath #(.MaxNodes(MaxNodes), .MaxRoute(MaxRoute)) u_dp (
    .clk_i, .rst_ni, .load_i(load), .item_i(in_item_i), .cmd_i(cmd),
    .count_i(count), .seg_i_i(seg_i), .seg_k_i(seg_k),
    .status_o(status), .out_item_o
  );

endmodule
